[hdl/ovle_pkg.sv]
// shared types and codes for the ordered value list engine
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package ovle_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_DUMP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP,
    S_RESP
  } state_t;

  localparam int ValueWidth = 32;
  localparam int CountWidth = 5;

  typedef struct packed {
    op_t                         op;
    logic signed [ValueWidth-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                      status;
    logic signed [ValueWidth-1:0] item_value;
    logic [CountWidth-1:0]        entry_count;
    logic                         last;
  } rsp_t;

endpackage

[hdl/ovle_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies; used by the top level for the entry store
`timescale 1ns / 1ps

module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ordered_value_list_engine_top.sv]
// operation: append writes the tail from the request; search scans in list order to a hit or
//   the end; delete scans likewise and on a hit shifts the later entries down one place; dump
//   reads every entry out in order; any operation on an empty list responds without a scan
// throughput: one transaction at a time; ready returns once the last response is loaded, so a
//   stalled output holds off the next transaction
// reset: rst (synchronous) empties the list; the entry ram is not cleared and needs no pass
`timescale 1ns / 1ps

module ordered_value_list_engine_top
  import ovle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // control state
  state_t        state, state_next;
  logic [CW-1:0] occ, occ_next;
  logic          pend, pend_next;         // ram read data is valid this cycle
  logic          rsp_valid_next;

  // working registers for the transaction in flight
  logic [CW-1:0]                idx, idx_next;           // next ram address to read
  logic [CW-1:0]                pend_pos, pend_pos_next; // list position of ram read data
  op_t                          op_r, op_next;
  logic signed [ValueWidth-1:0] val_r, val_next;
  status_t                      res_status, res_status_next;
  rsp_t                         rsp_next;

  // ram port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ValueWidth-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ValueWidth-1:0] ram_rdata;

  // condition terms
  logic accept;
  logic out_free;
  logic list_full;
  logic list_empty;
  logic more_to_read;
  logic pend_last;
  logic scan_match;
  logic scan_miss;
  logic dump_emit;

  assign accept       = req_valid && req_ready;
  assign req_ready    = (state == S_IDLE);
  assign out_free     = !rsp_valid || rsp_ready;
  assign list_full    = (occ == CW'(DEPTH));
  assign list_empty   = (occ == '0);
  assign more_to_read = (idx < occ);
  assign pend_last    = ((pend_pos + CW'(1)) == occ);
  assign scan_match   = pend && (ram_rdata == ValueWidth'(val_r));
  assign scan_miss    = pend && !scan_match && !more_to_read;
  assign dump_emit    = pend && out_free;

  ovle_ram #(
    .WIDTH(ValueWidth),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_APPEND: state_next = S_RESP;
            OP_SEARCH,
            OP_DELETE: state_next = list_empty ? S_RESP : S_SCAN;
            OP_DUMP:   state_next = list_empty ? S_RESP : S_DUMP;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_match) begin
          state_next = (op_r == OP_DELETE) ? S_SHIFT : S_RESP;
        end else if (scan_miss) begin
          state_next = S_RESP;
        end
      end
      S_SHIFT: begin
        // the entry at pend_pos is copied down one place this cycle when pend is set
        if (!more_to_read) begin
          state_next = S_RESP;
        end
      end
      S_DUMP: begin
        if (dump_emit && pend_last) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath, ram control and output register loads
  always_comb begin
    occ_next        = occ;
    pend_next       = 1'b0;
    idx_next        = idx;
    pend_pos_next   = pend_pos;
    op_next         = op_r;
    val_next        = val_r;
    res_status_next = res_status;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && !rsp_ready;
    ram_we          = 1'b0;
    ram_waddr       = occ[AW-1:0];
    ram_wdata       = ValueWidth'(req.value);
    ram_re          = 1'b0;
    ram_raddr       = idx[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next  = req.op;
          val_next = req.value;
          idx_next = '0;
          unique case (req.op)
            OP_APPEND: begin
              if (list_full) begin
                res_status_next = STAT_FULL;
              end else begin
                // tail write straight from the request
                ram_we          = 1'b1;
                occ_next        = occ + CW'(1);
                res_status_next = STAT_OK;
              end
            end
            OP_SEARCH,
            OP_DUMP: res_status_next = STAT_EMPTY;
            OP_DELETE: res_status_next = STAT_NOT_FOUND;
          endcase
        end
      end

      S_SCAN: begin
        if (scan_match) begin
          res_status_next = STAT_OK;
          // shift starts from the entry after the match
          idx_next        = pend_pos + CW'(1);
          pend_pos_next   = pend_pos;
        end else if (scan_miss) begin
          res_status_next = STAT_NOT_FOUND;
        end else if (more_to_read) begin
          ram_re        = 1'b1;
          pend_next     = 1'b1;
          pend_pos_next = idx;
          idx_next      = idx + CW'(1);
        end
      end

      S_SHIFT: begin
        // move entry pend_pos down one place
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pend_pos - CW'(1));
          ram_wdata = ram_rdata;
        end
        if (more_to_read) begin
          ram_re        = 1'b1;
          pend_next     = 1'b1;
          pend_pos_next = idx;
          idx_next      = idx + CW'(1);
        end else begin
          occ_next = occ - CW'(1);
        end
      end

      S_DUMP: begin
        if (dump_emit) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = STAT_OK;
          rsp_next.item_value  = ram_rdata;
          rsp_next.entry_count = CountWidth'(occ);
          rsp_next.last        = pend_last;
        end
        // stall the read while the pending entry waits on the output
        if (more_to_read && (!pend || out_free)) begin
          ram_re        = 1'b1;
          pend_next     = 1'b1;
          pend_pos_next = idx;
          idx_next      = idx + CW'(1);
        end else if (pend && !out_free) begin
          pend_next = 1'b1;
        end
      end

      S_RESP: begin
        if (out_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = res_status;
          rsp_next.item_value  = (op_r == OP_DUMP) ? '0 : val_r;
          rsp_next.entry_count = CountWidth'(occ);
          rsp_next.last        = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pend_pos   <= pend_pos_next;
    op_r       <= op_next;
    val_r      <= val_next;
    res_status <= res_status_next;
    rsp        <= rsp_next;
  end

  // the list never holds more than DEPTH entries
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(DEPTH))
    else $error("occupancy above depth");

  // occupancy only moves on an accepted append or at the end of a delete shift
  a_occ_source: assert property (@(posedge clk) disable iff (rst)
    !$stable(occ) |-> ($past(state) == S_IDLE || $past(state) == S_SHIFT))
    else $error("occupancy changed outside append or delete");

  // the entry ram is written only by an append or during the shift
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_IDLE && accept) || state == S_SHIFT))
    else $error("unexpected entry write");

endmodule
